@@ rtl/core/tcs_pkg.sv @@
// shared types and constants of the timelapse capture scheduler
package tcs_pkg;

  // field and register widths
  localparam int CFG_W  = 32;
  localparam int OUT_W  = 32;
  localparam int REQ_W  = 3;
  localparam int IDX_W  = 2;
  localparam int PROG_W = 8;

  // event codes
  localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
  localparam logic [REQ_W-1:0] REQ_START  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_STOP   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PAUSE  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_RESUME = 3'd4;
  localparam logic [REQ_W-1:0] REQ_DONE   = 3'd5;

  // configuration register indexes
  localparam logic [IDX_W-1:0] CFG_INTERVAL = 2'd0;
  localparam logic [IDX_W-1:0] CFG_MAX_FRM  = 2'd1;
  localparam logic [IDX_W-1:0] CFG_DURATION = 2'd2;

  // fixed values
  localparam logic [CFG_W-1:0] MIN_INTERVAL = 32'd1000;
  localparam int               PCT_SCALE    = 100;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUSY,
    ST_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic step;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic iter_done;
  } dp_status_t;

endpackage

@@ rtl/core/tcs_ctrl.sv @@
// controller state machine: handshakes and sequencing of the arithmetic steps
module tcs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  tcs_pkg::dp_status_t status,
  output tcs_pkg::ctl_cmd_t   cmd
);

  tcs_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            in_fire;
  logic            out_free;

  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      tcs_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = tcs_pkg::ST_BUSY;
      end
      tcs_pkg::ST_BUSY: begin
        if (status.iter_done) state_nxt = tcs_pkg::ST_EMIT;
      end
      tcs_pkg::ST_EMIT: begin
        if (out_free) state_nxt = tcs_pkg::ST_IDLE;
      end
      default: state_nxt = tcs_pkg::ST_IDLE;
    endcase
  end

  // outputs and commands
  always_comb begin
    in_ready     = 1'b0;
    cmd.accept   = 1'b0;
    cmd.step     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      tcs_pkg::ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      tcs_pkg::ST_BUSY: begin
        cmd.step = !status.iter_done;
      end
      tcs_pkg::ST_EMIT: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) out_valid_nxt = 1'b0;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tcs_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  // one item at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_ready)
    else $error("second transfer accepted while an item is in work");

  // a finished result always reaches the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tcs_pkg::ST_EMIT) && !out_valid_r |=> out_valid_r)
    else $error("finished result not loaded into empty output slot");

  // no result is dropped by a reload over a waiting one
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("waiting result lost");

endmodule

@@ rtl/core/tcs_dp.sv @@
// datapath: session state, event update, serial multiplier and divider, result register
module tcs_dp #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tcs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tcs_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic [tcs_pkg::REQ_W-1:0]    in_req_type,
  input  logic                         in_capture_success,
  input  tcs_pkg::ctl_cmd_t            cmd,
  output tcs_pkg::dp_status_t          status,
  output logic                         out_capture_request,
  output logic                         out_is_running,
  output logic                         out_is_paused,
  output logic [tcs_pkg::OUT_W-1:0]    out_frames_done,
  output logic [tcs_pkg::OUT_W-1:0]    out_frames_left,
  output logic [tcs_pkg::OUT_W-1:0]    out_elapsed_time,
  output logic [tcs_pkg::OUT_W-1:0]    out_wait_to_next,
  output logic [tcs_pkg::OUT_W-1:0]    out_time_left_estimate,
  output logic                         out_last_ok,
  output logic [tcs_pkg::PROG_W-1:0]   out_progress_percent
);

  localparam int CW    = COUNT_WIDTH;
  localparam int WW    = (CW > tcs_pkg::CFG_W) ? CW : tcs_pkg::CFG_W;
  localparam int ITER  = WW;
  localparam int CNT_W = $clog2(ITER + 1);
  localparam int DW    = tcs_pkg::CFG_W;

  // configuration
  logic [DW-1:0] interval_r, max_frames_r, duration_r;

  // session state
  logic [CW-1:0] now_r, now_nxt;
  logic [CW-1:0] start_r, start_nxt;
  logic [CW-1:0] last_cap_r, last_cap_nxt;
  logic          run_r, run_nxt;
  logic          pause_r, pause_nxt;
  logic          ok_r, ok_nxt;
  logic [CW-1:0] captured_r, captured_nxt;
  logic [WW-1:0] remaining_r, remaining_nxt;
  logic [CW-1:0] elapsed_r, elapsed_nxt;
  logic [CW-1:0] next_wait_r, next_wait_nxt;
  logic [CW-1:0] rem_time_r;

  // per-item work registers
  logic          req_r, req_nxt;
  logic          mul_en_r, mul_en_nxt;
  logic [CW-1:0] mcand_r, acc_r;
  logic [DW-1:0] mplier_r;
  logic [CW-1:0] dvd_r;
  logic [DW-1:0] rmd_r;
  logic [CNT_W-1:0] cnt_r;

  // event helpers
  logic [CW-1:0] now_inc, elapsed_tick, since;
  logic          dur_hit, frm_hit, due;
  logic [CW-1:0] cap100;

  // divider step
  logic [DW:0]   rmd_sh;
  logic          q_bit;

  assign now_inc      = now_r + 1'b1;
  assign elapsed_tick = now_inc - start_r;
  assign since        = now_inc - last_cap_r;
  assign dur_hit      = (duration_r != '0) && (WW'(elapsed_tick) >= WW'(duration_r));
  assign frm_hit      = (max_frames_r != '0) && (WW'(captured_r) >= WW'(max_frames_r));
  assign due          = WW'(since) >= WW'(interval_r);

  // state update for one event
  always_comb begin
    now_nxt       = now_r;
    start_nxt     = start_r;
    last_cap_nxt  = last_cap_r;
    run_nxt       = run_r;
    pause_nxt     = pause_r;
    ok_nxt        = ok_r;
    captured_nxt  = captured_r;
    remaining_nxt = remaining_r;
    elapsed_nxt   = elapsed_r;
    next_wait_nxt = next_wait_r;
    req_nxt       = 1'b0;
    mul_en_nxt    = 1'b0;
    case (in_req_type)
      tcs_pkg::REQ_TICK: begin
        now_nxt = now_inc;
        if (run_r && !pause_r) begin
          elapsed_nxt = elapsed_tick;
          if (dur_hit || frm_hit) begin
            run_nxt   = 1'b0;
            pause_nxt = 1'b0;
          end else begin
            next_wait_nxt = due ? '0 : CW'(WW'(interval_r) - WW'(since));
            mul_en_nxt    = (max_frames_r != '0);
            req_nxt       = (last_cap_r != '0) && due;
          end
        end
      end
      tcs_pkg::REQ_START: begin
        start_nxt     = now_r;
        last_cap_nxt  = '0;
        run_nxt       = 1'b1;
        pause_nxt     = 1'b0;
        captured_nxt  = '0;
        elapsed_nxt   = '0;
        ok_nxt        = 1'b1;
        remaining_nxt = (max_frames_r != '0) ? WW'(max_frames_r) : WW'({CW{1'b1}});
        req_nxt       = 1'b1;
      end
      tcs_pkg::REQ_STOP: begin
        run_nxt   = 1'b0;
        pause_nxt = 1'b0;
      end
      tcs_pkg::REQ_PAUSE: begin
        if (run_r) pause_nxt = 1'b1;
      end
      tcs_pkg::REQ_RESUME: begin
        if (run_r && pause_r) begin
          pause_nxt    = 1'b0;
          last_cap_nxt = now_r;
        end
      end
      tcs_pkg::REQ_DONE: begin
        last_cap_nxt = now_r;
        ok_nxt       = in_capture_success;
        if (in_capture_success) begin
          captured_nxt = captured_r + 1'b1;
          if ((max_frames_r != '0) && (remaining_r != '0)) begin
            remaining_nxt = WW'(CW'(remaining_r - 1'b1));
          end
        end
      end
      default: begin
        req_nxt = 1'b0;
      end
    endcase
  end

  // scaled frame count for the percent division
  assign cap100 = captured_nxt * CW'(tcs_pkg::PCT_SCALE);

  // restoring divider step
  assign rmd_sh = {rmd_r, dvd_r[CW-1]};
  assign q_bit  = rmd_sh >= {1'b0, max_frames_r};

  assign status.iter_done = (cnt_r == CNT_W'(ITER));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= tcs_pkg::MIN_INTERVAL;
      max_frames_r <= '0;
      duration_r   <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        tcs_pkg::CFG_INTERVAL: begin
          interval_r <= (cfg_wdata < tcs_pkg::MIN_INTERVAL) ? tcs_pkg::MIN_INTERVAL : cfg_wdata;
        end
        tcs_pkg::CFG_MAX_FRM:  max_frames_r <= cfg_wdata;
        tcs_pkg::CFG_DURATION: duration_r   <= cfg_wdata;
        default: begin
          duration_r <= duration_r;
        end
      endcase
    end
  end

  // session state and sequencing counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r       <= '0;
      start_r     <= '0;
      last_cap_r  <= '0;
      run_r       <= 1'b0;
      pause_r     <= 1'b0;
      ok_r        <= 1'b0;
      captured_r  <= '0;
      remaining_r <= '0;
      elapsed_r   <= '0;
      next_wait_r <= '0;
      rem_time_r  <= '0;
      req_r       <= 1'b0;
      mul_en_r    <= 1'b0;
      cnt_r       <= CNT_W'(ITER);
    end else begin
      if (cmd.accept) begin
        now_r       <= now_nxt;
        start_r     <= start_nxt;
        last_cap_r  <= last_cap_nxt;
        run_r       <= run_nxt;
        pause_r     <= pause_nxt;
        ok_r        <= ok_nxt;
        captured_r  <= captured_nxt;
        remaining_r <= remaining_nxt;
        elapsed_r   <= elapsed_nxt;
        next_wait_r <= next_wait_nxt;
        req_r       <= req_nxt;
        mul_en_r    <= mul_en_nxt;
        cnt_r       <= '0;
      end else if (cmd.step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.load_out && mul_en_r) rem_time_r <= acc_r;
    end
  end

  // shift-add multiplier and divider operands
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mcand_r  <= CW'(WW'(max_frames_r) - WW'(captured_r));
      mplier_r <= interval_r;
      acc_r    <= '0;
      dvd_r    <= cap100;
      rmd_r    <= '0;
    end else if (cmd.step) begin
      if (mplier_r[0]) acc_r <= acc_r + mcand_r;
      mcand_r  <= mcand_r << 1;
      mplier_r <= mplier_r >> 1;
      if (cnt_r < CNT_W'(CW)) begin
        rmd_r <= q_bit ? DW'(rmd_sh - {1'b0, max_frames_r}) : rmd_sh[DW-1:0];
        dvd_r <= {dvd_r[CW-2:0], q_bit};
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_capture_request    <= req_r;
      out_is_running         <= run_r;
      out_is_paused          <= pause_r;
      out_frames_done        <= tcs_pkg::OUT_W'(captured_r);
      out_frames_left        <= tcs_pkg::OUT_W'(remaining_r);
      out_elapsed_time       <= tcs_pkg::OUT_W'(elapsed_r);
      out_wait_to_next       <= tcs_pkg::OUT_W'(next_wait_r);
      out_time_left_estimate <= tcs_pkg::OUT_W'(mul_en_r ? acc_r : rem_time_r);
      out_last_ok            <= ok_r;
      out_progress_percent   <= (max_frames_r != '0) ? dvd_r[tcs_pkg::PROG_W-1:0] : '0;
    end
  end

endmodule

@@ rtl/core/timelapse_capture_scheduler_unit.sv @@
// Timelapse capture scheduler: one status result per event.
// Counters are COUNT_WIDTH bits wide and wrap. An accepted event updates the session
// state; the multiplier and divider then run one bit per cycle, and the result is
// loaded into the output register once it is free. The next event is taken only after
// that load, and is taken while the result still waits in the output register.
// Reset (synchronous, rst_n low) clears all session state; interval 1000, limits 0.
module timelapse_capture_scheduler_unit #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [tcs_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tcs_pkg::CFG_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [tcs_pkg::REQ_W-1:0]    in_req_type,
  input  logic                         in_capture_success,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_capture_request,
  output logic                         out_is_running,
  output logic                         out_is_paused,
  output logic [tcs_pkg::OUT_W-1:0]    out_frames_done,
  output logic [tcs_pkg::OUT_W-1:0]    out_frames_left,
  output logic [tcs_pkg::OUT_W-1:0]    out_elapsed_time,
  output logic [tcs_pkg::OUT_W-1:0]    out_wait_to_next,
  output logic [tcs_pkg::OUT_W-1:0]    out_time_left_estimate,
  output logic                         out_last_ok,
  output logic [tcs_pkg::PROG_W-1:0]   out_progress_percent
);

  tcs_pkg::ctl_cmd_t   cmd;
  tcs_pkg::dp_status_t status;

  // sequencing and handshakes
  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // state, arithmetic and result register
  tcs_dp #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_wr_en              (cfg_wr_en),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_req_type            (in_req_type),
    .in_capture_success     (in_capture_success),
    .cmd                    (cmd),
    .status                 (status),
    .out_capture_request    (out_capture_request),
    .out_is_running         (out_is_running),
    .out_is_paused          (out_is_paused),
    .out_frames_done        (out_frames_done),
    .out_frames_left        (out_frames_left),
    .out_elapsed_time       (out_elapsed_time),
    .out_wait_to_next       (out_wait_to_next),
    .out_time_left_estimate (out_time_left_estimate),
    .out_last_ok            (out_last_ok),
    .out_progress_percent   (out_progress_percent)
  );

  // a capture is only ever requested inside a running session
  a_req_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_capture_request |-> out_is_running)
    else $error("capture request outside a running session");

  // pause only exists within a session
  a_pause_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_paused |-> out_is_running)
    else $error("paused flag without running session");

  // a waiting result holds its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frames_done) &&
      $stable(out_capture_request))
    else $error("waiting result changed before its transfer");

endmodule
